// ----- rtl/rmp_pkg.sv -----
`timescale 1ns / 1ps

package rmp_pkg;

  // per-stage pipeline control handed to every cell
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  localparam int GUARD_BITS   = 24;
  localparam int VEL_BITS     = 16;
  localparam int DIV_BITS     = VEL_BITS + 1;
  localparam int ATAN_ENTRIES = 24;
  localparam int VEL_MAX      = 32767;
  localparam int VEL_MIN_MAG  = 32768;
  localparam int CFG_IDX_BITS = 8;

  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  localparam logic [CFG_IDX_BITS-1:0] REG_SENSOR_X = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_SENSOR_Y = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_SENSOR_Z = CFG_IDX_BITS'(2);
  localparam logic [CFG_IDX_BITS-1:0] REG_MODE     = CFG_IDX_BITS'(3);

  // atan(2^-i) in 2^-32 turns
  function automatic logic [31:0] atan_val(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/rmp_sqrt_cell.sv -----
`timescale 1ns / 1ps

// One result bit of two integer square roots (restoring, two radicand bits per cell).
module rmp_sqrt_cell #(
  parameter int R  = 25,
  parameter int SW = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmp_pkg::pipe_ctl_t  ctl_i,
  input  logic [2*R-1:0]      s_a_i,
  input  logic [R-1:0]        root_a_i,
  input  logic [R+1:0]        rem_a_i,
  input  logic [2*R-1:0]      s_b_i,
  input  logic [R-1:0]        root_b_i,
  input  logic [R+1:0]        rem_b_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic [2*R-1:0]      s_a_o,
  output logic [R-1:0]        root_a_o,
  output logic [R+1:0]        rem_a_o,
  output logic [2*R-1:0]      s_b_o,
  output logic [R-1:0]        root_b_o,
  output logic [R+1:0]        rem_b_o,
  output logic [SW-1:0]       side_o
);

  localparam int RW = R + 2;
  localparam int PW = 3 * R + RW;

  function automatic logic [PW-1:0] sq_step(input logic [2*R-1:0] s,
                                            input logic [R-1:0] root,
                                            input logic [RW-1:0] rem);
    logic [RW+1:0] remc;
    logic [RW+1:0] trial;
    logic [RW-1:0] rn;
    logic [R-1:0]  qn;
    remc  = {rem, s[2*R-1 -: 2]};
    trial = (RW+2)'({root, 2'b01});
    if (remc >= trial) begin
      rn = RW'(remc - trial);
      qn = {root[R-2:0], 1'b1};
    end else begin
      rn = RW'(remc);
      qn = {root[R-2:0], 1'b0};
    end
    return {s[2*R-3:0], 2'b00, qn, rn};
  endfunction

  logic [PW-1:0] step_a, step_b;
  logic          vld_r;
  logic [PW-1:0] a_r, b_r;
  logic [SW-1:0] side_r;

  assign step_a = sq_step(s_a_i, root_a_i, rem_a_i);
  assign step_b = sq_step(s_b_i, root_b_i, rem_b_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      a_r    <= step_a;
      b_r    <= step_b;
      side_r <= side_i;
    end
  end

  assign vld_o    = vld_r;
  assign s_a_o    = a_r[PW-1 -: 2*R];
  assign root_a_o = a_r[RW +: R];
  assign rem_a_o  = a_r[RW-1:0];
  assign s_b_o    = b_r[PW-1 -: 2*R];
  assign root_b_o = b_r[RW +: R];
  assign rem_b_o  = b_r[RW-1:0];
  assign side_o   = side_r;

endmodule

// ----- rtl/rmp_cordic_cell.sv -----
`timescale 1ns / 1ps

// One vectoring micro-rotation, applied to two vectors side by side.
module rmp_cordic_cell #(
  parameter int W   = 52,
  parameter int IDX = 0,
  parameter int SW  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmp_pkg::pipe_ctl_t  ctl_i,
  input  logic signed [W-1:0] xa_i,
  input  logic signed [W-1:0] ya_i,
  input  logic [31:0]         za_i,
  input  logic signed [W-1:0] xb_i,
  input  logic signed [W-1:0] yb_i,
  input  logic [31:0]         zb_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic signed [W-1:0] xa_o,
  output logic signed [W-1:0] ya_o,
  output logic [31:0]         za_o,
  output logic signed [W-1:0] xb_o,
  output logic signed [W-1:0] yb_o,
  output logic [31:0]         zb_o,
  output logic [SW-1:0]       side_o
);

  localparam logic [31:0] ATAN = rmp_pkg::atan_val(IDX);

  function automatic logic [2*W+31:0] cd_step(input logic signed [W-1:0] x,
                                              input logic signed [W-1:0] y,
                                              input logic [31:0] z);
    logic signed [W-1:0] xs;
    logic signed [W-1:0] ys;
    logic signed [W-1:0] xn;
    logic signed [W-1:0] yn;
    logic [31:0]         zn;
    xs = x >>> IDX;
    ys = y >>> IDX;
    if (!y[W-1]) begin
      xn = x + ys;
      yn = y - xs;
      zn = z + ATAN;
    end else begin
      xn = x - ys;
      yn = y + xs;
      zn = z - ATAN;
    end
    return {xn, yn, zn};
  endfunction

  logic [2*W+31:0] step_a, step_b;
  logic            vld_r;
  logic [2*W+31:0] a_r, b_r;
  logic [SW-1:0]   side_r;

  assign step_a = cd_step(xa_i, ya_i, za_i);
  assign step_b = cd_step(xb_i, yb_i, zb_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      a_r    <= step_a;
      b_r    <= step_b;
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign xa_o   = signed'(a_r[2*W+31 -: W]);
  assign ya_o   = signed'(a_r[W+31 -: W]);
  assign za_o   = a_r[31:0];
  assign xb_o   = signed'(b_r[2*W+31 -: W]);
  assign yb_o   = signed'(b_r[W+31 -: W]);
  assign zb_o   = b_r[31:0];
  assign side_o = side_r;

endmodule

// ----- rtl/rmp_div_cell.sv -----
`timescale 1ns / 1ps

// One quotient bit of a restoring divide: bit K is set when rem >= dxy << K.
module rmp_div_cell #(
  parameter int NW = 41,
  parameter int DW = 25,
  parameter int K  = 0,
  parameter int SW = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  rmp_pkg::pipe_ctl_t         ctl_i,
  input  logic [NW-1:0]              rem_i,
  input  logic [DW-1:0]              dxy_i,
  input  logic [rmp_pkg::DIV_BITS-1:0] q_i,
  input  logic [SW-1:0]              side_i,
  output logic                       vld_o,
  output logic [NW-1:0]              rem_o,
  output logic [DW-1:0]              dxy_o,
  output logic [rmp_pkg::DIV_BITS-1:0] q_o,
  output logic [SW-1:0]              side_o
);

  localparam int QB = rmp_pkg::DIV_BITS;

  logic [NW-1:0] trial;
  logic          take;
  logic          vld_r;
  logic [NW-1:0] rem_r;
  logic [DW-1:0] dxy_r;
  logic [QB-1:0] q_r;
  logic [SW-1:0] side_r;

  assign trial = NW'(dxy_i) << K;
  assign take  = (rem_i >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.en) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      rem_r  <= take ? rem_i - trial : rem_i;
      dxy_r  <= dxy_i;
      q_r    <= {q_i[QB-2:0], take};
      side_r <= side_i;
    end
  end

  assign vld_o  = vld_r;
  assign rem_o  = rem_r;
  assign dxy_o  = dxy_r;
  assign q_o    = q_r;
  assign side_o = side_r;

endmodule

// ----- rtl/radar_measurement_predict.sv -----
`timescale 1ns / 1ps

// Radar measurement predictor: takes a target position and horizontal velocity, subtracts
// the configured sensor position and returns range, azimuth, elevation and radial velocity.
// Fully pipelined: one request per cycle while the output is not stalled. Its depth is set by
// the chain of square-root cells (one per result bit), the CORDIC cells (one per stage, azimuth
// and elevation in parallel) and 17 divider cells for the radial velocity. The whole chain
// advances whenever the output register is empty or being taken. Sensor position and mode
// must be written while no request is in flight.
module radar_measurement_predict #(
  parameter int COORD_BITS    = 24,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // target_x, target_y, target_z, target_vx, target_vy
  input  logic [((3*COORD_BITS+32+7)/8)*8-1:0] in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // range_out, azimuth, elevation, radial_velocity
  output logic [((COORD_BITS+1+2*ANGLE_BITS+16+7)/8)*8-1:0] out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rmp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [COORD_BITS-1:0]             cfg_data
);

  localparam int C     = COORD_BITS;
  localparam int A     = ANGLE_BITS;
  localparam int CS    = CORDIC_STAGES;
  localparam int R     = C + 1;
  localparam int RW    = R + 2;
  localparam int VB    = rmp_pkg::VEL_BITS;
  localparam int DQ    = rmp_pkg::DIV_BITS;
  localparam int NMW   = R + VB + 1;
  localparam int NW    = C + VB + 1;
  localparam int CI    = R + 1;
  localparam int W     = CI + rmp_pkg::GUARD_BITS + 2;
  localparam int OUT_W = ((C + 1 + 2 * A + 16 + 7) / 8) * 8;
  localparam int SQ_SW = 3 * R + NMW + 1;
  localparam int CD_SW = 2 * R + NW + 6;
  localparam int DV_SW = R + 64 + 6;
  localparam int EL_LIM_I = 1 << (A - 2);
  localparam logic [31:0] ANG_RND = 32'd1 << (31 - A);

  // configuration
  logic [C-1:0] sensor_x_r, sensor_y_r, sensor_z_r;
  logic         mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_x_r <= '0;
      sensor_y_r <= '0;
      sensor_z_r <= '0;
      mode_r     <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        rmp_pkg::REG_SENSOR_X: sensor_x_r <= cfg_data;
        rmp_pkg::REG_SENSOR_Y: sensor_y_r <= cfg_data;
        rmp_pkg::REG_SENSOR_Z: sensor_z_r <= cfg_data;
        rmp_pkg::REG_MODE:     mode_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_tvalid_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // P0: offsets from sensor
  logic                 p0_vld_r;
  logic signed [R-1:0]  p0_dx_r, p0_dy_r, p0_dz_r;
  logic signed [VB-1:0] p0_vx_r, p0_vy_r;
  logic                 p0_mode_r;
  logic [C-1:0]         t_x, t_y, t_z;

  assign t_x = in_tdata[C-1:0];
  assign t_y = in_tdata[2*C-1:C];
  assign t_z = in_tdata[3*C-1:2*C];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else if (en) begin
      p0_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_dx_r   <= signed'({t_x[C-1], t_x}) - signed'({sensor_x_r[C-1], sensor_x_r});
      p0_dy_r   <= signed'({t_y[C-1], t_y}) - signed'({sensor_y_r[C-1], sensor_y_r});
      p0_dz_r   <= signed'({t_z[C-1], t_z}) - signed'({sensor_z_r[C-1], sensor_z_r});
      p0_vx_r   <= signed'(in_tdata[3*C+VB-1:3*C]);
      p0_vy_r   <= signed'(in_tdata[3*C+2*VB-1:3*C+VB]);
      p0_mode_r <= mode_r;
    end
  end

  // P1: squares and velocity dot product
  logic signed [2*R-1:0] sqx, sqy, sqz;
  logic signed [NMW-1:0] pvx, pvy;
  logic                  p1_vld_r;
  logic [2*R-1:0]        p1_sxy_r, p1_sxyz_r;
  logic signed [R-1:0]   p1_dx_r, p1_dy_r, p1_dz_r;
  logic signed [NMW-1:0] p1_num_r;
  logic                  p1_mode_r;

  assign sqx = p0_dx_r * p0_dx_r;
  assign sqy = p0_dy_r * p0_dy_r;
  assign sqz = p0_dz_r * p0_dz_r;
  assign pvx = p0_dx_r * p0_vx_r;
  assign pvy = p0_dy_r * p0_vy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= p0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_sxy_r  <= unsigned'(sqx + sqy);
      p1_sxyz_r <= unsigned'(sqx + sqy + sqz);
      p1_dx_r   <= p0_dx_r;
      p1_dy_r   <= p0_dy_r;
      p1_dz_r   <= p0_dz_r;
      p1_num_r  <= pvx + pvy;
      p1_mode_r <= p0_mode_r;
    end
  end

  // square-root chain: a = horizontal, b = full 3D
  logic             sq_vld   [0:R];
  logic [2*R-1:0]   sq_sa    [0:R];
  logic [R-1:0]     sq_ra    [0:R];
  logic [RW-1:0]    sq_ma    [0:R];
  logic [2*R-1:0]   sq_sb    [0:R];
  logic [R-1:0]     sq_rb    [0:R];
  logic [RW-1:0]    sq_mb    [0:R];
  logic [SQ_SW-1:0] sq_side  [0:R];

  assign sq_vld[0]  = p1_vld_r;
  assign sq_sa[0]   = p1_sxy_r;
  assign sq_ra[0]   = '0;
  assign sq_ma[0]   = '0;
  assign sq_sb[0]   = p1_sxyz_r;
  assign sq_rb[0]   = '0;
  assign sq_mb[0]   = '0;
  assign sq_side[0] = {p1_mode_r, p1_num_r, p1_dz_r, p1_dy_r, p1_dx_r};

  for (genvar j = 0; j < R; j++) begin : g_sqrt
    rmp_pkg::pipe_ctl_t ctl;
    assign ctl.en  = en;
    assign ctl.vld = sq_vld[j];
    rmp_sqrt_cell #(.R(R), .SW(SQ_SW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_i    (ctl),
      .s_a_i    (sq_sa[j]),
      .root_a_i (sq_ra[j]),
      .rem_a_i  (sq_ma[j]),
      .s_b_i    (sq_sb[j]),
      .root_b_i (sq_rb[j]),
      .rem_b_i  (sq_mb[j]),
      .side_i   (sq_side[j]),
      .vld_o    (sq_vld[j+1]),
      .s_a_o    (sq_sa[j+1]),
      .root_a_o (sq_ra[j+1]),
      .rem_a_o  (sq_ma[j+1]),
      .s_b_o    (sq_sb[j+1]),
      .root_b_o (sq_rb[j+1]),
      .rem_b_o  (sq_mb[j+1]),
      .side_o   (sq_side[j+1])
    );
  end

  // P2: round roots, velocity numerator
  logic signed [R-1:0]   s1_dx, s1_dy, s1_dz;
  logic signed [NMW-1:0] s1_num;
  logic                  s1_mode;
  logic [R-1:0]          dxy_c, rxyz_c;
  logic [NMW-1:0]        num_abs;

  assign s1_dx   = signed'(sq_side[R][R-1:0]);
  assign s1_dy   = signed'(sq_side[R][2*R-1:R]);
  assign s1_dz   = signed'(sq_side[R][3*R-1:2*R]);
  assign s1_num  = signed'(sq_side[R][3*R+NMW-1:3*R]);
  assign s1_mode = sq_side[R][SQ_SW-1];
  assign dxy_c   = sq_ra[R] + R'(sq_ma[R] > RW'(sq_ra[R]));
  assign rxyz_c  = sq_rb[R] + R'(sq_mb[R] > RW'(sq_rb[R]));
  assign num_abs = s1_num[NMW-1] ? unsigned'(-s1_num) : unsigned'(s1_num);

  logic                p2_vld_r;
  logic signed [R-1:0] p2_dx_r, p2_dy_r, p2_dz_r;
  logic [R-1:0]        p2_dxy_r, p2_range_r;
  logic [NW-1:0]       p2_n_r;
  logic                p2_neg_r, p2_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= sq_vld[R];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_dx_r    <= s1_dx;
      p2_dy_r    <= s1_dy;
      p2_dz_r    <= s1_dz;
      p2_dxy_r   <= dxy_c;
      p2_range_r <= s1_mode ? rxyz_c : dxy_c;
      p2_n_r     <= num_abs[NW-1:0] + NW'(dxy_c >> 1);
      p2_neg_r   <= s1_num[NMW-1];
      p2_mode_r  <= s1_mode;
    end
  end

  // P3: CORDIC setup, divider overflow check
  logic signed [CI-1:0] ax0, ay0, ax_f, ay_f, ex0, ey0;

  assign ax0  = CI'(p2_dx_r);
  assign ay0  = CI'(p2_dy_r);
  assign ax_f = ax0[CI-1] ? -ax0 : ax0;
  assign ay_f = ax0[CI-1] ? -ay0 : ay0;
  assign ex0  = signed'({1'b0, p2_dxy_r});
  assign ey0  = CI'(p2_dz_r);

  logic                p3_vld_r;
  logic signed [W-1:0] p3_ax_r, p3_ay_r, p3_ex_r, p3_ey_r;
  logic [31:0]         p3_az_r;
  logic [CD_SW-1:0]    p3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_ax_r   <= W'(ax_f) <<< rmp_pkg::GUARD_BITS;
      p3_ay_r   <= W'(ay_f) <<< rmp_pkg::GUARD_BITS;
      p3_az_r   <= ax0[CI-1] ? rmp_pkg::HALF_TURN : 32'd0;
      p3_ex_r   <= W'(ex0) <<< rmp_pkg::GUARD_BITS;
      p3_ey_r   <= W'(ey0) <<< rmp_pkg::GUARD_BITS;
      p3_side_r <= {(p2_dxy_r == '0) && (p2_dz_r == '0),
                    (p2_dx_r == '0) && (p2_dy_r == '0),
                    p2_mode_r,
                    p2_dxy_r == '0,
                    (p2_n_r >> DQ) >= NW'(p2_dxy_r),
                    p2_neg_r, p2_dxy_r, p2_n_r, p2_range_r};
    end
  end

  // CORDIC chain: a = azimuth, b = elevation
  logic                cd_vld  [0:CS];
  logic signed [W-1:0] cd_xa   [0:CS];
  logic signed [W-1:0] cd_ya   [0:CS];
  logic [31:0]         cd_za   [0:CS];
  logic signed [W-1:0] cd_xb   [0:CS];
  logic signed [W-1:0] cd_yb   [0:CS];
  logic [31:0]         cd_zb   [0:CS];
  logic [CD_SW-1:0]    cd_side [0:CS];

  assign cd_vld[0]  = p3_vld_r;
  assign cd_xa[0]   = p3_ax_r;
  assign cd_ya[0]   = p3_ay_r;
  assign cd_za[0]   = p3_az_r;
  assign cd_xb[0]   = p3_ex_r;
  assign cd_yb[0]   = p3_ey_r;
  assign cd_zb[0]   = 32'd0;
  assign cd_side[0] = p3_side_r;

  for (genvar j = 0; j < CS; j++) begin : g_cordic
    rmp_pkg::pipe_ctl_t ctl;
    assign ctl.en  = en;
    assign ctl.vld = cd_vld[j];
    rmp_cordic_cell #(.W(W), .IDX(j), .SW(CD_SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .xa_i   (cd_xa[j]),
      .ya_i   (cd_ya[j]),
      .za_i   (cd_za[j]),
      .xb_i   (cd_xb[j]),
      .yb_i   (cd_yb[j]),
      .zb_i   (cd_zb[j]),
      .side_i (cd_side[j]),
      .vld_o  (cd_vld[j+1]),
      .xa_o   (cd_xa[j+1]),
      .ya_o   (cd_ya[j+1]),
      .za_o   (cd_za[j+1]),
      .xb_o   (cd_xb[j+1]),
      .yb_o   (cd_yb[j+1]),
      .zb_o   (cd_zb[j+1]),
      .side_o (cd_side[j+1])
    );
  end

  // divider chain
  logic [R-1:0]  s2_range, s2_dxy;
  logic [NW-1:0] s2_n;
  logic [5:0]    s2_flags;

  assign s2_range = cd_side[CS][R-1:0];
  assign s2_n     = cd_side[CS][R+NW-1:R];
  assign s2_dxy   = cd_side[CS][2*R+NW-1:R+NW];
  assign s2_flags = cd_side[CS][CD_SW-1:2*R+NW];

  logic             dv_vld  [0:DQ];
  logic [NW-1:0]    dv_rem  [0:DQ];
  logic [R-1:0]     dv_dxy  [0:DQ];
  logic [DQ-1:0]    dv_q    [0:DQ];
  logic [DV_SW-1:0] dv_side [0:DQ];

  assign dv_vld[0]  = cd_vld[CS];
  assign dv_rem[0]  = s2_n;
  assign dv_dxy[0]  = s2_dxy;
  assign dv_q[0]    = '0;
  assign dv_side[0] = {s2_flags, cd_zb[CS], cd_za[CS], s2_range};

  for (genvar j = 0; j < DQ; j++) begin : g_div
    rmp_pkg::pipe_ctl_t ctl;
    assign ctl.en  = en;
    assign ctl.vld = dv_vld[j];
    rmp_div_cell #(.NW(NW), .DW(R), .K(DQ - 1 - j), .SW(DV_SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .rem_i  (dv_rem[j]),
      .dxy_i  (dv_dxy[j]),
      .q_i    (dv_q[j]),
      .side_i (dv_side[j]),
      .vld_o  (dv_vld[j+1]),
      .rem_o  (dv_rem[j+1]),
      .dxy_o  (dv_dxy[j+1]),
      .q_o    (dv_q[j+1]),
      .side_o (dv_side[j+1])
    );
  end

  // output stage: angle rounding, elevation clamp, velocity saturation
  logic [R-1:0]        f_range;
  logic [31:0]         f_za, f_zb, az_rnd, el_rnd;
  logic                f_neg, f_ovf, f_dzero, f_mode, f_azero, f_ezero;
  logic signed [A-1:0] el_raw, el_lim, el_c;
  logic [DQ-1:0]       f_q;
  logic [VB-1:0]       vel_c;

  assign f_range = dv_side[DQ][R-1:0];
  assign f_za    = dv_side[DQ][R+31:R];
  assign f_zb    = dv_side[DQ][R+63:R+32];
  assign f_neg   = dv_side[DQ][R+64];
  assign f_ovf   = dv_side[DQ][R+65];
  assign f_dzero = dv_side[DQ][R+66];
  assign f_mode  = dv_side[DQ][R+67];
  assign f_azero = dv_side[DQ][R+68];
  assign f_ezero = dv_side[DQ][R+69];
  assign f_q     = dv_q[DQ];

  assign az_rnd = (f_azero ? 32'd0 : f_za) + ANG_RND;
  assign el_rnd = (f_ezero ? 32'd0 : f_zb) + ANG_RND;
  assign el_raw = signed'(el_rnd[31 -: A]);
  assign el_lim = A'(EL_LIM_I);

  always_comb begin
    if (!f_mode) begin
      el_c = '0;
    end else if (el_raw > el_lim) begin
      el_c = el_lim;
    end else if (el_raw < -el_lim) begin
      el_c = -el_lim;
    end else begin
      el_c = el_raw;
    end
  end

  always_comb begin
    if (f_dzero) begin
      vel_c = '0;
    end else if (!f_neg) begin
      vel_c = (f_ovf || f_q > DQ'(rmp_pkg::VEL_MAX)) ? VB'(rmp_pkg::VEL_MAX) : f_q[VB-1:0];
    end else begin
      vel_c = (f_ovf || f_q > DQ'(rmp_pkg::VEL_MIN_MAG)) ?
              VB'(rmp_pkg::VEL_MIN_MAG) : VB'(-f_q[VB-1:0]);
    end
  end

  logic [R-1:0]  out_range_r;
  logic [A-1:0]  out_az_r, out_el_r;
  logic [VB-1:0] out_vel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      out_tvalid_r <= dv_vld[DQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_range_r <= f_range;
      out_az_r    <= az_rnd[31 -: A];
      out_el_r    <= el_c;
      out_vel_r   <= vel_c;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_vel_r, out_el_r, out_az_r, out_range_r});

`ifndef ASSERT_OFF
  a_el_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> (signed'(out_el_r) <= el_lim) && (signed'(out_el_r) >= -el_lim))
    else $error("elevation outside clamp range");

  a_sqrt_to_p2: assert property (@(posedge clk) disable iff (!rst_n)
    en && sq_vld[R] |=> p2_vld_r)
    else $error("request lost after square-root chain");

  a_p2_to_p3: assert property (@(posedge clk) disable iff (!rst_n)
    en && p2_vld_r |=> p3_vld_r)
    else $error("request lost at CORDIC setup");
`endif

endmodule

// ----- verif/rmp_checker.sv -----
`timescale 1ns / 1ps

module rmp_checker #(
  parameter int COORD_BITS    = 24,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16,
  parameter int IN_W          = ((3*COORD_BITS+32+7)/8)*8,
  parameter int OUT_W         = ((COORD_BITS+1+2*ANGLE_BITS+16+7)/8)*8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [IN_W-1:0]                  in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [OUT_W-1:0]                 out_tdata,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [rmp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]            cfg_data,
  output int                               fail_count,
  output int                               pending
);

  localparam int RANGE_BITS = COORD_BITS + 1;

  typedef struct packed {
    logic [rmp_pkg::VEL_BITS-1:0] vel;
    logic [ANGLE_BITS-1:0]        elev;
    logic [ANGLE_BITS-1:0]        azim;
    logic [RANGE_BITS-1:0]        rng;
  } meas_t;

  logic signed [COORD_BITS-1:0] sens_x, sens_y, sens_z;
  logic                         sph_mode;
  meas_t                        meas_q[$];

  // atan(2^-i) in 2^-32 turns, independent copy
  logic [31:0] atan_lut [0:23] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81};

  function automatic logic [35:0] isqrt_rnd(input logic [71:0] s);
    logic [35:0] r, c;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      c = r | (36'd1 << b);
      if ({36'd0, c} * {36'd0, c} <= s) r = c;
    end
    if (s > {36'd0, r} * {36'd0, r + 36'd1}) r = r + 36'd1;
    return r;
  endfunction

  function automatic logic [31:0] vec_angle(input longint x, input longint y);
    logic [31:0] z;
    longint      xs, ys;
    z = '0;
    if (x == 0 && y == 0) return 32'd0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = rmp_pkg::HALF_TURN;
    end
    x = x <<< 24;
    y = y <<< 24;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += atan_lut[i];
      end else begin
        x -= ys; y += xs; z -= atan_lut[i];
      end
    end
    return z;
  endfunction

  function automatic logic [ANGLE_BITS-1:0] to_angle(input logic [31:0] z);
    logic [31:0] a;
    a = (z + (32'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
    return a[ANGLE_BITS-1:0];
  endfunction

  function automatic meas_t predict_meas(input logic [IN_W-1:0] d);
    meas_t   m;
    longint  dx, dy, dz, vx, vy, num, e, lim;
    logic [71:0] sxy, s3;
    logic [35:0] dxy, rng;
    logic [63:0] q, an;
    dx = longint'($signed(d[COORD_BITS-1:0])) - longint'(sens_x);
    dy = longint'($signed(d[2*COORD_BITS-1:COORD_BITS])) - longint'(sens_y);
    dz = longint'($signed(d[3*COORD_BITS-1:2*COORD_BITS])) - longint'(sens_z);
    vx = longint'($signed(d[3*COORD_BITS+15:3*COORD_BITS]));
    vy = longint'($signed(d[3*COORD_BITS+31:3*COORD_BITS+16]));
    sxy = 72'(dx * dx) + 72'(dy * dy);
    dxy = isqrt_rnd(sxy);
    m.elev = '0;
    if (sph_mode) begin
      s3 = sxy + 72'(dz * dz);
      rng = isqrt_rnd(s3);
      lim = longint'(1) << (ANGLE_BITS - 2);
      e = longint'($signed(to_angle(vec_angle(longint'(dxy), dz))));
      if (e > lim) e = lim;
      if (e < -lim) e = -lim;
      m.elev = e[ANGLE_BITS-1:0];
    end else begin
      rng = dxy;
    end
    if (rng > (36'd1 << RANGE_BITS) - 1) rng = (36'd1 << RANGE_BITS) - 1;
    m.rng = rng[RANGE_BITS-1:0];
    m.azim = to_angle(vec_angle(dx, dy));
    if (dxy == 0) begin
      m.vel = '0;
    end else begin
      num = dx * vx + dy * vy;
      an = (num < 0) ? 64'(-num) : 64'(num);
      q = (an + 64'(dxy / 2)) / 64'(dxy);
      if (num >= 0) m.vel = (q > rmp_pkg::VEL_MAX) ? 16'sd32767 : q[15:0];
      else m.vel = (q > rmp_pkg::VEL_MIN_MAG) ? 16'h8000 : 16'(-q);
    end
    return m;
  endfunction

  assign pending = meas_q.size();

  always @(posedge clk) begin
    meas_t got, want;
    if (!rst_n) begin
      sens_x <= '0;
      sens_y <= '0;
      sens_z <= '0;
      sph_mode <= 1'b1;
      fail_count <= 0;
      meas_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rmp_pkg::REG_SENSOR_X: sens_x <= cfg_data;
          rmp_pkg::REG_SENSOR_Y: sens_y <= cfg_data;
          rmp_pkg::REG_SENSOR_Z: sens_z <= cfg_data;
          rmp_pkg::REG_MODE:     sph_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) meas_q.push_back(predict_meas(in_tdata));
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(meas_t)-1:0];
        if (meas_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %h", got);
        end else begin
          want = meas_q.pop_front();
          if (got !== want || out_tdata[OUT_W-1:$bits(meas_t)] !== '0) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: range %0d/%0d az %0d/%0d el %0d/%0d vel %0d/%0d",
                       want.rng, got.rng, $signed(want.azim), $signed(got.azim),
                       $signed(want.elev), $signed(got.elev),
                       $signed(want.vel), $signed(got.vel));
          end
        end
      end
    end
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int CB    = 24;
  localparam int IN_W  = ((3*CB+32+7)/8)*8;
  localparam int OUT_W = ((CB+1+2*16+16+7)/8)*8;
  localparam int LATENCY = CB + 16 + 23;
  localparam int WDOG_LIMIT = 5000;
  localparam int N_RANDOM = 700;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid = 1'b0, cfg_ready;
  logic [rmp_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;
  int fail_count, pending;
  int idle_cycles = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  radar_measurement_predict dut (.*);

  rmp_checker chk (.*);

  // receiver stalls in bursts
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [rmp_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [CB-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic send_target(input logic [CB-1:0] x, y, z, input logic [15:0] vx, vy);
    int n;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      n = $urandom_range(1, 13);
      repeat (n) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_W'({vy, vx, z, y, x});
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [CB-1:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return CB'($urandom);
      1: return CB'($signed(12'($urandom)));
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return CB'($signed(18'($urandom)));
    endcase
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) begin
      if (i > n - 60) calm = 1'b1;
      send_target(rnd_coord(), rnd_coord(), rnd_coord(), 16'($urandom), 16'($urandom));
    end
    in_tvalid <= 1'b0;
    calm = 1'b0;
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: zero vector, negative x axis, axes, extremes, zero horizontal distance
    send_target(0, 0, 0, 16'h7FFF, 16'h8000);
    send_target(24'hFFFF00, 0, 0, 16'h0100, 0);
    send_target(0, 24'h000100, 0, 0, 16'h0100);
    send_target(0, 0, 24'h000500, 16'h1234, 16'h4321);
    send_target(0, 0, 24'hFFF000, 0, 0);
    send_target(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF);
    send_target(24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000);
    send_target(24'h800000, 24'h7FFFFF, 0, 16'h7FFF, 16'h8000);
    send_target(24'h000001, 0, 0, 16'h7FFF, 0);
    send_target(24'h000001, 0, 0, 16'h8000, 0);
    send_target(24'h000003, 24'h000004, 24'hFFFFFF, 16'h0001, 16'hFFFF);
    send_target(24'hFFFFFF, 24'hFFFFFF, 24'h000001, 16'h0002, 16'h0003);
    in_tvalid <= 1'b0;
    drain();
    write_reg(rmp_pkg::REG_MODE, 0);
    write_reg(rmp_pkg::REG_SENSOR_X, 24'h800000);
    write_reg(rmp_pkg::REG_SENSOR_Y, 24'h7FFFFF);
    write_reg(rmp_pkg::REG_SENSOR_Z, 24'h123456);
    write_reg(8'd7, 24'hFFFFFF);  // unmapped index, dropped
    send_target(24'h800000, 24'h7FFFFF, 24'h000000, 16'h1111, 16'h2222);
    send_target(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h8000);
    random_phase(N_RANDOM / 4);
    drain();
    write_reg(rmp_pkg::REG_MODE, 1);
    write_reg(rmp_pkg::REG_SENSOR_X, 24'h7FFFFF);
    write_reg(rmp_pkg::REG_SENSOR_Y, 24'h800000);
    write_reg(rmp_pkg::REG_SENSOR_Z, 24'h800000);
    random_phase(N_RANDOM / 4);
    drain();
    write_reg(rmp_pkg::REG_SENSOR_X, CB'($urandom));
    write_reg(rmp_pkg::REG_SENSOR_Y, CB'($signed(14'($urandom))));
    write_reg(rmp_pkg::REG_SENSOR_Z, CB'($urandom));
    random_phase(N_RANDOM / 4);
    drain();
    write_reg(rmp_pkg::REG_SENSOR_X, 0);
    write_reg(rmp_pkg::REG_SENSOR_Y, 0);
    write_reg(rmp_pkg::REG_SENSOR_Z, 0);
    random_phase(N_RANDOM / 4);
    drain();
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rmp_pkg.sv
rtl/rmp_sqrt_cell.sv
rtl/rmp_cordic_cell.sv
rtl/rmp_div_cell.sv
rtl/radar_measurement_predict.sv
verif/rmp_checker.sv
verif/tb.sv
